// ----- hw/rtl/euler_totient_trial_division_defines.svh -----
// Assertion macros shared by the totient block.
// Each macro checks on the rising clock edge and is held off while reset is low.
`ifndef EULER_TOTIENT_TRIAL_DIVISION_DEFINES_SVH
`define EULER_TOTIENT_TRIAL_DIVISION_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ETT_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define ETT_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- hw/rtl/ett_pkg.sv -----
package ett_pkg;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;       // take a new request into the working registers
        logic sqr;        // register the square of the trial divisor
        logic start_div;  // start a division of the remaining value by the divisor
        logic take;       // account for one hit of the divisor
        logic next_div;   // step to the next trial divisor
        logic left;       // account for a leftover prime
        logic out_load;   // move the finished totient into the output register
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic num_zero;   // the offered number is zero
        logic is_two;     // the trial divisor is two
        logic sq_le;      // divisor squared does not exceed the remaining value
        logic div_done;   // the divider has finished
        logic div_exact;  // the last division left no remainder
        logic out_free;   // the output register can take a new result
    } t_sts;

endpackage

// ----- hw/rtl/ett_number_if.sv -----
interface ett_number_if #(
    parameter int WIDTH = 16
) ();
    logic             valid;
    logic             ready;
    logic [WIDTH-1:0] number;

    modport source (output valid, output number, input ready);
    modport sink   (input valid, input number, output ready);
endinterface

// ----- hw/rtl/ett_totient_if.sv -----
interface ett_totient_if #(
    parameter int WIDTH = 16
) ();
    logic             valid;
    logic             ready;
    logic [WIDTH-1:0] totient;

    modport source (output valid, output totient, input ready);
    modport sink   (input valid, input totient, output ready);
endinterface

// ----- hw/rtl/ett_div.sv -----
`include "euler_totient_trial_division_defines.svh"

module ett_div #(
    parameter int WIDTH = 16
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [WIDTH-1:0] i_dividend,
    input  logic [WIDTH-1:0] i_divisor,
    output logic             o_done,
    output logic [WIDTH-1:0] o_quotient,
    output logic [WIDTH-1:0] o_remainder
);
    localparam int CW = $clog2(WIDTH + 1);

    logic          r_busy;
    logic          r_done;
    logic [CW-1:0] r_cnt;
    logic [WIDTH-1:0] r_quo;
    logic [WIDTH-1:0] r_rem;
    logic [WIDTH-1:0] r_dvs;

    logic [WIDTH:0] w_trial;
    logic [WIDTH:0] w_diff;
    logic           w_ge;

    // Restoring division, one quotient bit per cycle.
    assign w_trial = {r_rem, r_quo[WIDTH-1]};
    assign w_diff  = w_trial - {1'b0, r_dvs};
    assign w_ge    = (w_trial >= {1'b0, r_dvs});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CW'(WIDTH);
            end else if (r_busy) begin
                r_cnt <= r_cnt - CW'(1);
                if (r_cnt == CW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= i_dividend;
            r_rem <= '0;
            r_dvs <= i_divisor;
        end else if (r_busy) begin
            r_quo <= {r_quo[WIDTH-2:0], w_ge};
            r_rem <= w_ge ? w_diff[WIDTH-1:0] : w_trial[WIDTH-1:0];
        end
    end

    assign o_done      = r_done;
    assign o_quotient  = r_quo;
    assign o_remainder = r_rem;

    `ETT_ASSERT_SAME(a_no_restart, i_start, !r_busy, "divider restarted while busy")
    `ETT_ASSERT_NEXT(a_done_pulse, r_done, !r_done && !r_busy, "divider done held too long")
endmodule

// ----- hw/rtl/ett_dp.sv -----
`include "euler_totient_trial_division_defines.svh"

module ett_dp #(
    parameter int WIDTH = 16
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  ett_pkg::t_cmd     i_cmd,
    output ett_pkg::t_sts     o_sts,
    input  logic [WIDTH-1:0]  i_number,
    output logic [WIDTH-1:0]  o_totient,
    output logic              o_out_valid,
    input  logic              i_out_ready
);
    import ett_pkg::*;

    logic [WIDTH-1:0]   r_rem;
    logic [WIDTH-1:0]   r_d;
    logic [WIDTH-1:0]   r_tot;
    logic [WIDTH-1:0]   r_last;
    logic [2*WIDTH-1:0] r_sq;
    logic [WIDTH-1:0]   r_totient;
    logic               r_out_valid;

    logic [WIDTH-1:0]   w_factor;
    logic [2*WIDTH-1:0] w_prod;
    logic               w_div_done;
    logic [WIDTH-1:0]   w_quo;
    logic [WIDTH-1:0]   w_div_rem;
    logic               w_rem_gt1;

    ett_div #(.WIDTH(WIDTH)) u_div (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (i_cmd.start_div),
        .i_dividend  (r_rem),
        .i_divisor   (r_d),
        .o_done      (w_div_done),
        .o_quotient  (w_quo),
        .o_remainder (w_div_rem)
    );

    assign w_rem_gt1 = (r_rem > WIDTH'(1));

    // A first hit of a prime scales by p-1, a repeated hit by p.
    always_comb begin
        if (i_cmd.left) begin
            w_factor = (r_last == r_rem) ? r_rem : r_rem - WIDTH'(1);
        end else begin
            w_factor = (r_last == r_d) ? r_d : r_d - WIDTH'(1);
        end
    end

    assign w_prod = (2*WIDTH)'(r_tot) * (2*WIDTH)'(w_factor);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rem       <= '0;
            r_d         <= '0;
            r_tot       <= '0;
            r_last      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.load) begin
                r_rem  <= i_number;
                r_d    <= (i_number == '0) ? '0 : WIDTH'(2);
                r_tot  <= (i_number == '0) ? '0 : WIDTH'(1);
                r_last <= '0;
            end
            if (i_cmd.take) begin
                r_tot  <= w_prod[WIDTH-1:0];
                r_rem  <= w_quo;
                r_last <= r_d;
            end
            if (i_cmd.next_div) begin
                r_d <= o_sts.is_two ? WIDTH'(3) : r_d + WIDTH'(2);
            end
            if (i_cmd.left && w_rem_gt1) begin
                r_tot  <= w_prod[WIDTH-1:0];
                r_last <= r_rem;
                r_rem  <= WIDTH'(1);
            end
            if (i_cmd.out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.sqr) begin
            r_sq <= (2*WIDTH)'(r_d) * (2*WIDTH)'(r_d);
        end
        if (i_cmd.out_load) begin
            r_totient <= r_tot;
        end
    end

    always_comb begin
        o_sts           = '0;
        o_sts.num_zero  = (i_number == '0);
        o_sts.is_two    = (r_d == WIDTH'(2));
        o_sts.sq_le     = (r_sq <= {{WIDTH{1'b0}}, r_rem});
        o_sts.div_done  = w_div_done;
        o_sts.div_exact = (w_div_rem == '0);
        o_sts.out_free  = !r_out_valid || i_out_ready;
    end

    assign o_totient   = r_totient;
    assign o_out_valid = r_out_valid;

    `ETT_ASSERT_SAME(a_take_exact, i_cmd.take, o_sts.div_exact, "factor taken with remainder")
    `ETT_ASSERT_SAME(a_rem_nonzero, r_d != '0, r_rem != '0, "remaining value fell to zero")
endmodule

// ----- hw/rtl/ett_ctrl.sv -----
`include "euler_totient_trial_division_defines.svh"

module ett_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    input  ett_pkg::t_sts i_sts,
    output ett_pkg::t_cmd o_cmd
);
    import ett_pkg::*;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_SQR   = 3'd1;
    localparam logic [2:0] S_CMP   = 3'd2;
    localparam logic [2:0] S_DIV   = 3'd3;
    localparam logic [2:0] S_HIT   = 3'd4;
    localparam logic [2:0] S_START = 3'd5;
    localparam logic [2:0] S_LEFT  = 3'd6;
    localparam logic [2:0] S_DONE  = 3'd7;

    logic [2:0] r_state;
    logic [2:0] n_state;

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = i_sts.num_zero ? S_DONE : S_SQR;
                end
            end
            S_SQR: begin
                o_cmd.sqr = 1'b1;
                n_state   = S_CMP;
            end
            S_CMP: begin
                // Factor two is always tried; odd divisors only up to the square root.
                if (i_sts.is_two || i_sts.sq_le) begin
                    o_cmd.start_div = 1'b1;
                    n_state         = S_DIV;
                end else begin
                    n_state = S_LEFT;
                end
            end
            S_DIV: begin
                if (i_sts.div_done) begin
                    n_state = S_HIT;
                end
            end
            S_HIT: begin
                if (i_sts.div_exact) begin
                    o_cmd.take = 1'b1;
                    n_state    = S_START;
                end else begin
                    o_cmd.next_div = 1'b1;
                    n_state        = S_SQR;
                end
            end
            S_START: begin
                o_cmd.start_div = 1'b1;
                n_state         = S_DIV;
            end
            S_LEFT: begin
                o_cmd.left = 1'b1;
                n_state    = S_DONE;
            end
            S_DONE: begin
                if (i_sts.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    `ETT_ASSERT_SAME(a_out_free, o_cmd.out_load, i_sts.out_free, "result loaded over a full output")
endmodule

// ----- hw/rtl/euler_totient_trial_division.sv -----
// Euler totient by trial division. Each request on the number channel carries one
// unsigned integer, and the block returns one request on the totient channel with the
// count of integers from 1 to that number that are coprime to it. An input of one gives
// one, and an input of zero gives zero. Factor two is removed first, then odd divisors
// from three upward are tried while the divisor squared does not exceed the remaining
// value, and a leftover above one is taken as a prime. The first hit of a prime scales
// the running product by p-1 and each further hit by p. The block works on one number
// at a time. Every division is done by a restoring divider that produces one quotient
// bit per cycle, and that divider sets the pace, so numbers with small factors finish
// far sooner. A new number is taken as soon as the previous result sits in the output
// register, even while that result still waits to be taken.
module euler_totient_trial_division #(
    parameter int WIDTH = 16
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    ett_number_if.sink   i_number_ch,
    ett_totient_if.source o_totient_ch
);
    import ett_pkg::*;

    // Commands and status run only between the controller and the datapath.
    t_cmd w_cmd;
    t_sts w_sts;

    // The controller sequences load, the divisor square check, the division loop,
    // the leftover prime and the hand-off to the output register.
    ett_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_number_ch.valid),
        .o_in_ready (i_number_ch.ready),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd)
    );

    // The datapath holds the remaining value, the trial divisor, the running product,
    // the last prime hit, the divider and the output register.
    ett_dp #(.WIDTH(WIDTH)) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .o_sts       (w_sts),
        .i_number    (i_number_ch.number),
        .o_totient   (o_totient_ch.totient),
        .o_out_valid (o_totient_ch.valid),
        .i_out_ready (o_totient_ch.ready)
    );
endmodule
